// ===== src/pls_pkg.sv =====
`default_nettype none

package pls_pkg;

  localparam int DEPTH      = 32;
  localparam int DATA_WIDTH = 32;

  // widths of the request and result fields
  localparam int CMD_W   = 2;
  localparam int WHERE_W = 2;
  localparam int POS_W   = 6;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int CNT_OUT_W = 6;
  localparam int ELEM_W  = 32;

  // internal widths
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = POS_W + CW;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

  localparam logic [WHERE_W-1:0] WHERE_FRONT = 2'd0;
  localparam logic [WHERE_W-1:0] WHERE_BACK  = 2'd1;
  localparam logic [WHERE_W-1:0] WHERE_AT    = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

endpackage

`default_nettype wire

// ===== src/positional_list_store.sv =====
// Ordered list of up to DEPTH words kept in one single-port-write, registered-read RAM.
// A request is taken only while the block is idle; one finished result may still wait at
// the output. Insert at 1-based position p shifts the count-p+1 later words up one slot
// through the RAM, one word per cycle, then writes the new word. Delete at p shifts
// count-p words down. Insert at the back and delete at the back take no shift. A dump
// streams one word per cycle from the RAM read port while out_ready stays high.
// Error and status-only results skip the RAM and go straight to S_DONE.
`default_nettype none

module positional_list_store (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [pls_pkg::CMD_W-1:0]      cmd,
  input  wire logic [pls_pkg::WHERE_W-1:0]    where,
  input  wire logic [pls_pkg::POS_W-1:0]      position,
  input  wire logic [pls_pkg::VALUE_W-1:0]    value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [pls_pkg::STAT_W-1:0]     status,
  output logic      [pls_pkg::CNT_OUT_W-1:0]  count,
  output logic      [pls_pkg::ELEM_W-1:0]     element,
  output logic      [pls_pkg::CNT_OUT_W-1:0]  element_pos,
  output logic                                last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_PUT  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                        state, state_next;
  logic [pls_pkg::CW-1:0]            count_q;
  logic [pls_pkg::CMD_W-1:0]         op_q;
  logic [pls_pkg::STAT_W-1:0]        st_q;
  logic [pls_pkg::AW-1:0]            idx_q;
  logic [pls_pkg::DATA_WIDTH-1:0]    val_q;
  logic [pls_pkg::AW-1:0]            rd_next;
  logic [pls_pkg::CW-1:0]            rd_left;
  logic [pls_pkg::AW-1:0]            ra_q;
  logic                              rv;

  // decode of the incoming request
  logic [pls_pkg::STAT_W-1:0]        d_st;
  logic [1:0]                        d_state;
  logic [pls_pkg::CW-1:0]            d_idx;
  logic [pls_pkg::AW-1:0]            d_first;
  logic [pls_pkg::CW-1:0]            d_left;
  logic                              d_dec;
  logic                              bad;
  logic [pls_pkg::PW-1:0]            pos_w;
  logic [pls_pkg::PW-1:0]            cnt_w;

  logic                              in_acc;
  logic                              out_free;
  logic                              consume;
  logic                              issue;
  logic                              walk_end;
  logic                              we;
  logic [pls_pkg::AW-1:0]            waddr;
  logic [pls_pkg::DATA_WIDTH-1:0]    wdata;
  logic [pls_pkg::DATA_WIDTH-1:0]    rdata;
  logic [pls_pkg::CW-1:0]            dump_pos;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign pos_w    = pls_pkg::PW'(position);
  assign cnt_w    = pls_pkg::PW'(count_q);

  always_comb begin
    d_st    = pls_pkg::ST_OK;
    d_state = S_DONE;
    d_idx   = '0;
    d_first = '0;
    d_left  = '0;
    d_dec   = 1'b0;
    bad     = 1'b0;
    case (cmd)
      pls_pkg::CMD_INSERT: begin
        case (where)
          pls_pkg::WHERE_FRONT: d_idx = '0;
          pls_pkg::WHERE_BACK:  d_idx = count_q;
          pls_pkg::WHERE_AT: begin
            bad   = (pos_w == '0) || (pos_w > cnt_w + pls_pkg::PW'(1));
            d_idx = pls_pkg::CW'(position) - pls_pkg::CW'(1);
          end
          default: bad = 1'b1;
        endcase
        if (bad) begin
          d_st = pls_pkg::ST_BADPOS;
        end else if (count_q == pls_pkg::CW'(pls_pkg::DEPTH)) begin
          d_st = pls_pkg::ST_FULL;
        end else begin
          d_left  = count_q - d_idx;
          d_first = pls_pkg::AW'(count_q - pls_pkg::CW'(1));
          d_state = (d_left == '0) ? S_PUT : S_WALK;
        end
      end
      pls_pkg::CMD_DELETE: begin
        if (count_q == '0) begin
          d_st = pls_pkg::ST_EMPTY;
        end else begin
          case (where)
            pls_pkg::WHERE_FRONT: d_idx = '0;
            pls_pkg::WHERE_BACK:  d_idx = count_q - pls_pkg::CW'(1);
            pls_pkg::WHERE_AT: begin
              bad   = (pos_w == '0) || (pos_w > cnt_w);
              d_idx = pls_pkg::CW'(position) - pls_pkg::CW'(1);
            end
            default: bad = 1'b1;
          endcase
          if (bad) begin
            d_st = pls_pkg::ST_BADPOS;
          end else begin
            d_left  = count_q - pls_pkg::CW'(1) - d_idx;
            d_first = pls_pkg::AW'(d_idx + pls_pkg::CW'(1));
            if (d_left == '0) begin
              d_dec = 1'b1;
            end else begin
              d_state = S_WALK;
            end
          end
        end
      end
      pls_pkg::CMD_DUMP: begin
        if (count_q == '0) begin
          d_st = pls_pkg::ST_EMPTY;
        end else begin
          d_first = '0;
          d_left  = count_q;
          d_state = S_WALK;
        end
      end
      default: d_st = pls_pkg::ST_OK;
    endcase
  end

  // rdata is a pipeline stage: it drains into a ram write or the output register
  assign consume  = (state == S_WALK) && rv && ((op_q != pls_pkg::CMD_DUMP) || out_free);
  assign issue    = (state == S_WALK) && (rd_left != '0) && (!rv || consume);
  assign walk_end = (state == S_WALK) && (rd_left == '0) && (!rv || consume);
  assign dump_pos = pls_pkg::CW'(ra_q) + pls_pkg::CW'(1);

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    if (consume && op_q == pls_pkg::CMD_INSERT) begin
      we    = 1'b1;
      waddr = ra_q + pls_pkg::AW'(1);
    end else if (consume && op_q == pls_pkg::CMD_DELETE) begin
      we    = 1'b1;
      waddr = ra_q - pls_pkg::AW'(1);
    end else if (state == S_PUT) begin
      we    = 1'b1;
      waddr = idx_q;
      wdata = val_q;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_acc) state_next = d_state;
      S_WALK: begin
        if (walk_end) begin
          case (op_q)
            pls_pkg::CMD_INSERT: state_next = S_PUT;
            pls_pkg::CMD_DELETE: state_next = S_DONE;
            default:             state_next = S_IDLE;
          endcase
        end
      end
      S_PUT:  state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  pls_ram #(
    .WIDTH (pls_pkg::DATA_WIDTH),
    .DEPTH (pls_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (issue),
    .raddr (rd_next),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count_q   <= '0;
      rv        <= 1'b0;
      rd_left   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (in_acc) begin
        op_q    <= cmd;
        st_q    <= d_st;
        idx_q   <= pls_pkg::AW'(d_idx);
        val_q   <= pls_pkg::DATA_WIDTH'(value);
        rd_next <= d_first;
        rd_left <= d_left;
        if (d_dec) begin
          count_q <= count_q - pls_pkg::CW'(1);
        end
      end

      if (issue) begin
        ra_q    <= rd_next;
        rd_left <= rd_left - pls_pkg::CW'(1);
        if (op_q == pls_pkg::CMD_INSERT) begin
          rd_next <= rd_next - pls_pkg::AW'(1);
        end else begin
          rd_next <= rd_next + pls_pkg::AW'(1);
        end
        rv <= 1'b1;
      end else if (consume) begin
        rv <= 1'b0;
      end

      if (walk_end && op_q == pls_pkg::CMD_DELETE) begin
        count_q <= count_q - pls_pkg::CW'(1);
      end
      if (state == S_PUT) begin
        count_q <= count_q + pls_pkg::CW'(1);
      end

      if (consume && op_q == pls_pkg::CMD_DUMP) begin
        out_valid   <= 1'b1;
        status      <= pls_pkg::ST_OK;
        count       <= pls_pkg::CNT_OUT_W'(count_q);
        element     <= pls_pkg::ELEM_W'(rdata);
        element_pos <= pls_pkg::CNT_OUT_W'(dump_pos);
        last        <= (dump_pos == count_q);
      end else if (state == S_DONE && out_free) begin
        out_valid   <= 1'b1;
        status      <= st_q;
        count       <= pls_pkg::CNT_OUT_W'(count_q);
        element     <= '0;
        element_pos <= '0;
        last        <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // no read data may be left in the ram stage once a new request can be taken
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!rv && rd_left == '0))
    else $error("read data left in flight at idle");

  // a dump never modifies the store
  a_dump_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && op_q == pls_pkg::CMD_DUMP) |-> !we)
    else $error("ram write during dump");

  // the count only moves while a request is being worked
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !in_acc) |=> (count_q == $past(count_q)))
    else $error("count changed while idle");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUT) |-> (count_q < pls_pkg::CW'(pls_pkg::DEPTH)))
    else $error("insert into a full list");

endmodule

`default_nettype wire

// ===== src/pls_ram.sv =====
`default_nettype none

module pls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
